// ===== rtl/core/slc_pkg.sv =====
package slc_pkg;

  // Result codes
  typedef enum logic [2:0] {
    KIND_INVALID = 3'd0,
    KIND_CHAR    = 3'd1,
    KIND_INT     = 3'd2,
    KIND_FLOAT   = 3'd3,
    KIND_DOUBLE  = 3'd4
  } kind_t;

  // Position in the sign / digits / dot / digits / f form
  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_SIGN   = 3'd1,
    PH_INT    = 3'd2,
    PH_DOT    = 3'd3,
    PH_FRAC   = 3'd4,
    PH_SUFFIX = 3'd5,
    PH_FAIL   = 3'd6
  } phase_t;

  // Token state, everything but the magnitude accumulator
  typedef struct packed {
    logic [2:0] byte_count;
    logic [7:0] first_byte;
    logic       all_digits_ok;
    logic       is_negative;
    phase_t     phase;
    logic [7:0] kw_hits;
  } tok_info_t;

  localparam tok_info_t TOK_INFO_RST = '{
    byte_count:    3'd0,
    first_byte:    8'd0,
    all_digits_ok: 1'b1,
    is_negative:   1'b0,
    phase:         PH_START,
    kw_hits:       8'hFF
  };

  // Characters of interest
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Keywords: first four are float, last four are double
  localparam int NUM_KW   = 8;
  localparam int NUM_KW_F = 4;

  localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
    '{CH_I,     CH_N, CH_F, CH_F, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{CH_PLUS,  CH_I, CH_N, CH_F, CH_F,   CH_NUL, CH_NUL, CH_NUL},
    '{CH_MINUS, CH_I, CH_N, CH_F, CH_F,   CH_NUL, CH_NUL, CH_NUL},
    '{CH_N,     CH_A, CH_N, CH_F, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{CH_I,     CH_N, CH_F, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{CH_PLUS,  CH_I, CH_N, CH_F, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{CH_MINUS, CH_I, CH_N, CH_F, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{CH_N,     CH_A, CH_N, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL}
  };

  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd4, 3'd5, 3'd5, 3'd4, 3'd3, 3'd4, 3'd4, 3'd3
  };

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

// ===== rtl/core/scalar_literal_classifier.sv =====
// Scalar literal classifier: one byte per transaction, kind emitted on the last byte.
// Throughput: one byte per cycle, unless a last byte waits for a stalled result register.
// Path: the last byte is held in the input register, then goes through the per-byte update
//   and classification into the result register.
// Reset: synchronous, active low; clears both stages and returns the token state to start.
module scalar_literal_classifier #(
  parameter int INT_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_kind
);

  logic                  s1_vld_r;
  logic [7:0]            s1_ch_r;
  logic                  s1_last_r;
  logic                  out_valid_r;
  slc_pkg::kind_t        out_kind_r;

  logic                  out_free;
  logic                  s1_go;
  logic                  in_acc;
  slc_pkg::tok_info_t    info_nxt;
  logic [INT_WIDTH-1:0]  mag_nxt;
  slc_pkg::kind_t        kind;

  // Handshake: a byte without last never needs the result slot
  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_vld_r && (!s1_last_r || out_free);
  assign in_stall = s1_vld_r && !s1_go;
  assign in_acc   = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_acc) begin
      s1_vld_r <= 1'b1;
    end else if (s1_go) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ch_r   <= in_ch;
      s1_last_r <= in_last;
    end
  end

  slc_token #(
    .INT_WIDTH (INT_WIDTH)
  ) u_token (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_en  (s1_go),
    .ch       (s1_ch_r),
    .last     (s1_last_r),
    .info_nxt (info_nxt),
    .mag_nxt  (mag_nxt)
  );

  slc_classify #(
    .INT_WIDTH (INT_WIDTH)
  ) u_classify (
    .info (info_nxt),
    .mag  (mag_nxt),
    .kind (kind)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_go && s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_go && s1_last_r) begin
      out_kind_r <= kind;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;

endmodule

// ===== rtl/core/slc_token.sv =====
// Per-byte token state tracker: digit accumulator, form DFA, keyword matchers
module slc_token #(
  parameter int INT_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  byte_en,
  input  logic [7:0]            ch,
  input  logic                  last,
  output slc_pkg::tok_info_t    info_nxt,
  output logic [INT_WIDTH-1:0]  mag_nxt
);

  // Saturation value: one above the largest negative magnitude
  localparam logic [INT_WIDTH-1:0] MAG_SAT =
    {1'b1, {(INT_WIDTH-2){1'b0}}, 1'b1};
  localparam logic [INT_WIDTH+3:0] MAG_SAT_EXT =
    {5'b00001, {(INT_WIDTH-2){1'b0}}, 1'b1};

  slc_pkg::tok_info_t       info_r;
  logic [INT_WIDTH-1:0]     mag_r;
  logic                     dig;
  logic                     sign_ch;
  logic                     first_pos;
  logic [INT_WIDTH+3:0]     prod;
  logic [7:0]               dval;

  assign dig       = slc_pkg::is_digit(ch);
  assign sign_ch   = (ch == slc_pkg::CH_PLUS) || (ch == slc_pkg::CH_MINUS);
  assign first_pos = (info_r.byte_count == 3'd0);
  assign dval      = ch - slc_pkg::CH_ZERO;

  // Multiply by ten and add the digit
  assign prod = {1'b0, mag_r, 3'b000} + {3'b000, mag_r, 1'b0}
              + {{(INT_WIDTH-4){1'b0}}, dval};

  always_comb begin
    if (!dig) begin
      mag_nxt = mag_r;
    end else if (prod > MAG_SAT_EXT) begin
      mag_nxt = MAG_SAT;
    end else begin
      mag_nxt = prod[INT_WIDTH-1:0];
    end
  end

  // Simple fields
  always_comb begin
    info_nxt = info_r;
    if (first_pos) begin
      info_nxt.first_byte  = ch;
      info_nxt.is_negative = (ch == slc_pkg::CH_MINUS);
    end
    if (!dig && !(first_pos && sign_ch)) begin
      info_nxt.all_digits_ok = 1'b0;
    end
    if (info_r.byte_count != 3'd7) begin
      info_nxt.byte_count = info_r.byte_count + 3'd1;
    end

    // Numeric form DFA
    case (info_r.phase)
      slc_pkg::PH_START: begin
        if (sign_ch)  info_nxt.phase = slc_pkg::PH_SIGN;
        else if (dig) info_nxt.phase = slc_pkg::PH_INT;
        else          info_nxt.phase = slc_pkg::PH_FAIL;
      end
      slc_pkg::PH_SIGN: begin
        info_nxt.phase = dig ? slc_pkg::PH_INT : slc_pkg::PH_FAIL;
      end
      slc_pkg::PH_INT: begin
        if (dig)                         info_nxt.phase = slc_pkg::PH_INT;
        else if (ch == slc_pkg::CH_DOT)  info_nxt.phase = slc_pkg::PH_DOT;
        else                             info_nxt.phase = slc_pkg::PH_FAIL;
      end
      slc_pkg::PH_DOT: begin
        info_nxt.phase = dig ? slc_pkg::PH_FRAC : slc_pkg::PH_FAIL;
      end
      slc_pkg::PH_FRAC: begin
        if (dig)                       info_nxt.phase = slc_pkg::PH_FRAC;
        else if (ch == slc_pkg::CH_F)  info_nxt.phase = slc_pkg::PH_SUFFIX;
        else                           info_nxt.phase = slc_pkg::PH_FAIL;
      end
      default: begin
        info_nxt.phase = slc_pkg::PH_FAIL;
      end
    endcase

    // Keyword matchers, one per keyword, all compared at the current position
    for (int k = 0; k < slc_pkg::NUM_KW; k++) begin
      info_nxt.kw_hits[k] = info_r.kw_hits[k]
                          && (info_r.byte_count < slc_pkg::KW_LEN[k])
                          && (slc_pkg::KW_TEXT[k][info_r.byte_count] == ch);
    end
  end

  // Token state: advance per byte, back to reset after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      info_r <= slc_pkg::TOK_INFO_RST;
      mag_r  <= '0;
    end else if (byte_en) begin
      if (last) begin
        info_r <= slc_pkg::TOK_INFO_RST;
        mag_r  <= '0;
      end else begin
        info_r <= info_nxt;
        mag_r  <= mag_nxt;
      end
    end
  end

endmodule

// ===== rtl/core/slc_classify.sv =====
// Token kind from the final token state; checks in char, int, float, double order
module slc_classify #(
  parameter int INT_WIDTH = 32
) (
  input  slc_pkg::tok_info_t    info,
  input  logic [INT_WIDTH-1:0]  mag,
  output slc_pkg::kind_t        kind
);

  localparam logic [INT_WIDTH-1:0] POS_LIM = {1'b0, {(INT_WIDTH-1){1'b1}}};
  localparam logic [INT_WIDTH-1:0] NEG_LIM = {1'b1, {(INT_WIDTH-1){1'b0}}};

  logic is_char;
  logic is_int;
  logic kw_float;
  logic kw_double;

  assign is_char = (info.byte_count == 3'd1) && !slc_pkg::is_digit(info.first_byte);
  assign is_int  = info.all_digits_ok
                && ((mag <= POS_LIM) || (info.is_negative && (mag == NEG_LIM)));

  // Keyword complete: still matching and length reached
  always_comb begin
    kw_float  = 1'b0;
    kw_double = 1'b0;
    for (int k = 0; k < slc_pkg::NUM_KW; k++) begin
      if (info.kw_hits[k] && (info.byte_count == slc_pkg::KW_LEN[k])) begin
        if (k < slc_pkg::NUM_KW_F) kw_float  = 1'b1;
        else                       kw_double = 1'b1;
      end
    end
  end

  always_comb begin
    if (is_char) begin
      kind = slc_pkg::KIND_CHAR;
    end else if (is_int) begin
      kind = slc_pkg::KIND_INT;
    end else if ((info.phase == slc_pkg::PH_SUFFIX) || kw_float) begin
      kind = slc_pkg::KIND_FLOAT;
    end else if ((info.phase == slc_pkg::PH_FRAC) || kw_double) begin
      kind = slc_pkg::KIND_DOUBLE;
    end else begin
      kind = slc_pkg::KIND_INVALID;
    end
  end

endmodule

// ===== dv/tb_scalar_literal_classifier.sv =====
`timescale 1ns / 100ps

module tb_scalar_literal_classifier;

  localparam int          CLK_HALF    = 6;
  localparam int          RST_CYCLES  = 8;
  localparam int          RAND_BYTES  = 1150;
  localparam int          CYCLE_LIMIT = 100000;
  localparam int          HOLD_AT     = 400;
  localparam int          HOLD_CYCLES = 200;
  localparam int          DRAIN       = 10;
  // 32-bit int range; the accumulator parks one above the largest negative magnitude
  localparam logic [63:0] POS_MAX     = (64'd1 << 31) - 64'd1;
  localparam logic [63:0] MAG_SAT     = (64'd1 << 31) + 64'd1;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } lit_byte_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_ch;
  logic       in_last;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] out_kind;

  scalar_literal_classifier u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_ch     (in_ch),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind)
  );

  // Keywords: the first four are float, the rest double
  string kw_words [8] = '{"inff", "+inff", "-inff", "nanf", "inf", "+inf", "-inf", "nan"};

  lit_byte_t       text_queue [$];
  slc_pkg::kind_t  kind_expected [$];
  int              total_bytes;
  int              bytes_accepted;
  int              fail_count;
  int              cycle_count;
  logic            in_taken;

  // Token state of the predictor
  logic [2:0]       tok_len;
  logic [7:0]       tok_first;
  logic             tok_digits_ok;
  logic             tok_neg;
  logic [63:0]      tok_mag;
  slc_pkg::phase_t  tok_phase;
  logic [7:0]       tok_kw;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= slc_pkg::CH_ZERO) && (c <= slc_pkg::CH_NINE);
  endfunction

  function automatic slc_pkg::phase_t phase_after(input slc_pkg::phase_t ph,
                                                  input logic [7:0] c);
    case (ph)
      slc_pkg::PH_START: begin
        if (c == slc_pkg::CH_PLUS || c == slc_pkg::CH_MINUS) return slc_pkg::PH_SIGN;
        return is_dec(c) ? slc_pkg::PH_INT : slc_pkg::PH_FAIL;
      end
      slc_pkg::PH_SIGN: return is_dec(c) ? slc_pkg::PH_INT : slc_pkg::PH_FAIL;
      slc_pkg::PH_INT: begin
        if (is_dec(c)) return slc_pkg::PH_INT;
        return (c == slc_pkg::CH_DOT) ? slc_pkg::PH_DOT : slc_pkg::PH_FAIL;
      end
      slc_pkg::PH_DOT: return is_dec(c) ? slc_pkg::PH_FRAC : slc_pkg::PH_FAIL;
      slc_pkg::PH_FRAC: begin
        if (is_dec(c)) return slc_pkg::PH_FRAC;
        return (c == slc_pkg::CH_F) ? slc_pkg::PH_SUFFIX : slc_pkg::PH_FAIL;
      end
      default: return slc_pkg::PH_FAIL;
    endcase
  endfunction

  // Kind of the token held in the predictor state; char, int, float, double in turn
  function automatic slc_pkg::kind_t token_kind();
    if (tok_len == 3'd1 && !is_dec(tok_first)) return slc_pkg::KIND_CHAR;
    if (tok_digits_ok && tok_mag <= POS_MAX + (tok_neg ? 64'd1 : 64'd0))
      return slc_pkg::KIND_INT;
    if (tok_phase == slc_pkg::PH_SUFFIX) return slc_pkg::KIND_FLOAT;
    for (int k = 0; k < 4; k++)
      if (tok_kw[k] && tok_len == kw_words[k].len()) return slc_pkg::KIND_FLOAT;
    if (tok_phase == slc_pkg::PH_FRAC) return slc_pkg::KIND_DOUBLE;
    for (int k = 4; k < 8; k++)
      if (tok_kw[k] && tok_len == kw_words[k].len()) return slc_pkg::KIND_DOUBLE;
    return slc_pkg::KIND_INVALID;
  endfunction

  task automatic clear_token();
    tok_len       = 3'd0;
    tok_first     = 8'd0;
    tok_digits_ok = 1'b1;
    tok_neg       = 1'b0;
    tok_mag       = 64'd0;
    tok_phase     = slc_pkg::PH_START;
    tok_kw        = 8'hFF;
  endtask

  // Fold one accepted byte into the token; the last byte yields the expected kind
  task automatic literal_step(input logic [7:0] c, input logic is_last);
    logic [2:0]  pos;
    logic [63:0] dval;
    pos = tok_len;
    if (pos == 3'd0) begin
      tok_first = c;
      tok_neg   = (c == slc_pkg::CH_MINUS);
    end
    if (is_dec(c)) begin
      dval = 64'(c - slc_pkg::CH_ZERO);
      if (tok_mag > (MAG_SAT - dval) / 64'd10) tok_mag = MAG_SAT;
      else tok_mag = tok_mag * 64'd10 + dval;
    end else if (!(pos == 3'd0 && (c == slc_pkg::CH_PLUS || c == slc_pkg::CH_MINUS))) begin
      tok_digits_ok = 1'b0;
    end
    tok_phase = phase_after(tok_phase, c);
    for (int k = 0; k < 8; k++)
      if (pos >= kw_words[k].len() || kw_words[k][pos] != c) tok_kw[k] = 1'b0;
    if (tok_len < 3'd7) tok_len = tok_len + 3'd1;
    if (is_last) begin
      kind_expected.push_back(token_kind());
      clear_token();
    end
  endtask

  task automatic add_byte(input logic [7:0] c, input logic is_last);
    lit_byte_t b;
    b.ch   = c;
    b.last = is_last;
    text_queue.push_back(b);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], i == s.len() - 1);
  endtask

  function automatic string digit_run(input int n);
    string r;
    r = "";
    for (int i = 0; i < n; i++) r = {r, $sformatf("%0d", $urandom_range(0, 9))};
    return r;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Run timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d of %0d bytes accepted, %0d results pending",
               $time, bytes_accepted, total_bytes, kind_expected.size());
      $display("** scalar_literal_classifier: FAILED **");
      $finish;
    end
  end

  // Input acceptance feeds the predictor; results are checked against the oldest expectation
  always @(posedge clk) begin
    slc_pkg::kind_t want;
    if (rst_n) begin
      in_taken = in_valid && !in_stall;
      if (in_taken) begin
        literal_step(in_ch, in_last);
        bytes_accepted++;
      end
      if (out_valid && !out_stall) begin
        if (kind_expected.size() == 0) begin
          $display("%0t: result with nothing expected, actual kind %0d", $time, out_kind);
          fail_count++;
        end else begin
          want = kind_expected.pop_front();
          if (out_kind !== want) begin
            $display("%0t: kind mismatch, expected %0d (%s) actual %0d",
                     $time, want, want.name(), out_kind);
            fail_count++;
          end
        end
      end
    end else begin
      in_taken = 1'b0;
    end
  end

  // Driver: bursts of transactions separated by random gaps
  lit_byte_t cur_byte;
  int        burst_left;
  int        gap_left;

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (gap_left > 0 || text_queue.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
      end else begin
        cur_byte = text_queue.pop_front();
        in_valid <= 1'b1;
        in_ch    <= cur_byte.ch;
        in_last  <= cur_byte.last;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Receiver stall pattern, with one long hold-off to back up the pipeline
  int   stall_mode;
  int   mode_left;
  int   hold_left;
  logic hold_done;

  always @(negedge clk) begin
    if (rst_n) begin
      if (!hold_done && bytes_accepted >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(20, 120);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 9) < 3);
          2: out_stall <= ~out_stall;
          default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    string    s;
    string    odd_chars;
    int       pick;
    int       n;
    longint   mag;
    logic [7:0] c;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_ch          = 8'd0;
    in_last        = 1'b0;
    out_stall      = 1'b0;
    in_taken       = 1'b0;
    bytes_accepted = 0;
    fail_count     = 0;
    cycle_count    = 0;
    burst_left     = 0;
    gap_left       = 0;
    stall_mode     = 0;
    mode_left      = 0;
    hold_left      = 0;
    hold_done      = 1'b0;
    odd_chars      = "+-.09finax";
    clear_token();

    // Directed: lone bytes, int limits, saturation, decimal-point forms, keywords
    add_text("a");
    add_text("+");
    add_text("-");
    add_byte(8'h00, 1'b1);
    add_byte(8'hFF, 1'b1);
    add_byte(8'h80, 1'b1);
    add_text("7");
    add_text("+5");
    add_text("2147483647");
    add_text("-2147483648");
    add_text("2147483648");
    add_text("-2147483649");
    add_text("99999999999999999999");
    add_text("3.14f");
    add_text("-0.5");
    add_text("1.");
    add_text(".5");
    add_text("1.5x");
    foreach (kw_words[k]) add_text(kw_words[k]);
    add_text("infff");

    // Random tokens, mostly well formed with random content
    while (text_queue.size() < RAND_BYTES) begin
      pick = $urandom_range(0, 99);
      s    = "";
      if (pick < 30) begin
        case ($urandom_range(0, 3))
          0: s = "-";
          1: s = "+";
          default: s = "";
        endcase
        if ($urandom_range(0, 4) == 0) s = {s, "0000000"};
        s = {s, digit_run($urandom_range(1, 12))};
        add_text(s);
      end else if (pick < 42) begin
        // magnitudes around the int range edges
        mag = 64'sd2147483647 + longint'($urandom_range(0, 6)) - 64'sd3;
        if ($urandom_range(0, 1)) s = "-";
        s = {s, $sformatf("%0d", mag)};
        add_text(s);
      end else if (pick < 67) begin
        // sign, digits, dot, digits, suffix, each part sometimes missing
        if ($urandom_range(0, 2) == 0) s = $urandom_range(0, 1) ? "-" : "+";
        if ($urandom_range(0, 9) != 0) s = {s, digit_run($urandom_range(1, 4))};
        if ($urandom_range(0, 9) != 0) s = {s, "."};
        if ($urandom_range(0, 9) != 0) s = {s, digit_run($urandom_range(1, 4))};
        if ($urandom_range(0, 1)) s = {s, "f"};
        if ($urandom_range(0, 14) == 0) s = {s, "f"};
        if (s.len() == 0) s = "5";
        add_text(s);
      end else if (pick < 82) begin
        s = kw_words[$urandom_range(0, 7)];
        if ($urandom_range(0, 3) == 0) begin
          n = $urandom_range(0, s.len() - 1);
          s.putc(n, odd_chars[$urandom_range(0, odd_chars.len() - 1)]);
        end else if ($urandom_range(0, 5) == 0) begin
          s = {s, "f"};
        end
        add_text(s);
      end else if (pick < 92) begin
        add_byte(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        // noise, half of it drawn from the characters the parser cares about
        n = $urandom_range(1, 9);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 1)) c = odd_chars[$urandom_range(0, odd_chars.len() - 1)];
          else c = 8'($urandom_range(0, 255));
          add_byte(c, i == n - 1);
        end
      end
    end
    total_bytes = text_queue.size();

    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (bytes_accepted != total_bytes) @(posedge clk);
    while (kind_expected.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (fail_count == 0) begin
      $display("** scalar_literal_classifier: PASSED **");
    end else begin
      $display("** scalar_literal_classifier: FAILED **");
    end
    $finish;
  end

endmodule

// ===== scalar_literal_classifier.f =====
rtl/core/slc_pkg.sv
rtl/core/slc_token.sv
rtl/core/slc_classify.sv
rtl/core/scalar_literal_classifier.sv
dv/tb_scalar_literal_classifier.sv
